/* src/lswd_pkg.sv */
// ----------------------------------------------------------------------------
// lswd_pkg: shared types and constants of the load signature window detector
// Command codes, register indexes, reset values, the per-slot window table
// and the control record that travels down the slot chain.
// ----------------------------------------------------------------------------
package lswd_pkg;

	localparam int NUM_SLOTS_DEF    = 7;
	localparam int SAMPLE_WIDTH_DEF = 32;

	localparam int CMD_W   = 2;
	localparam int SLOT_W  = 3;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CNT_W   = 16;
	localparam int MASK_W  = 7;
	localparam int INIT_ENTRIES = 7;

	localparam logic [CMD_W-1:0] CMD_DETECT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LEARN  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_LENGTH      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_WIDEN_BELOW = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_LIMIT_RST    = 8'd3;
	localparam logic [CFG_W-1:0] LEARN_LENGTH_RST      = 8'd100;
	localparam logic [CFG_W-1:0] LEARN_WIDEN_BELOW_RST = 8'd50;

	// window reset values, Q8.24 amperes
	localparam logic [63:0] INIT_HIGH [INIT_ENTRIES] = '{
		64'd689566, 64'd2747921, 64'd2389700, 64'd1834076,
		64'd2151431, 64'd2926068, 64'd6111319
	};
	localparam logic [63:0] INIT_LOW [INIT_ENTRIES] = '{
		64'd687264, 64'd2717585, 64'd2375660, 64'd1802855,
		64'd2115037, 64'd2886112, 64'd6096663
	};

	function automatic logic [63:0] init_high_f(int k);
		logic [63:0] v;
		v = '0;
		if (k < INIT_ENTRIES) begin
			v = INIT_HIGH[k];
		end
		return v;
	endfunction

	function automatic logic [63:0] init_low_f(int k);
		logic [63:0] v;
		v = '0;
		if (k < INIT_ENTRIES) begin
			v = INIT_LOW[k];
		end
		return v;
	endfunction

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] slot;
		logic              widen;
		logic              done;
		logic [CFG_W-1:0]  remaining;
		logic [MASK_W-1:0] mask;
	} lswd_ctl_t;

endpackage

/* src/lswd_if.sv */
// ----------------------------------------------------------------------------
// lswd channel interfaces
// Valid/ready channels for command beats in and status beats out.
// ----------------------------------------------------------------------------
interface lswd_in_if #(
	parameter int SAMPLE_WIDTH = lswd_pkg::SAMPLE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic [lswd_pkg::CMD_W-1:0]    command;
	logic [SAMPLE_WIDTH-1:0]       current_sample;
	logic [lswd_pkg::SLOT_W-1:0]   slot;

	modport source (output valid, command, current_sample, slot, input ready);
	modport sink   (input valid, command, current_sample, slot, output ready);
endinterface

interface lswd_out_if;
	logic                          valid;
	logic                          ready;
	logic [lswd_pkg::MASK_W-1:0]   on_mask;
	logic                          learn_done;
	logic [lswd_pkg::CFG_W-1:0]    learn_remaining;

	modport source (output valid, on_mask, learn_done, learn_remaining, input ready);
	modport sink   (input valid, on_mask, learn_done, learn_remaining, output ready);
endinterface

/* src/lswd_ctrl.sv */
// ----------------------------------------------------------------------------
// lswd_ctrl: configuration registers and shared learn countdown
// Tags each accepted beat with its countdown outcome before it enters the
// slot chain.
// ----------------------------------------------------------------------------
module lswd_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lswd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lswd_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             accept,
	input  logic [lswd_pkg::CMD_W-1:0]       command,
	input  logic [lswd_pkg::SLOT_W-1:0]      slot,
	output lswd_pkg::lswd_ctl_t              ctl,
	output logic [lswd_pkg::CFG_W-1:0]       debounce_limit
);
	import lswd_pkg::*;

	logic [CFG_W-1:0] limit_q;
	logic [CFG_W-1:0] length_q;
	logic [CFG_W-1:0] widen_below_q;
	logic [CFG_W-1:0] countdown_q;
	logic [CFG_W-1:0] countdown_dec;
	logic [CFG_W-1:0] countdown_nxt;
	logic             is_learn;

	assign debounce_limit = limit_q;
	assign is_learn       = (command == CMD_LEARN);
	assign countdown_dec  = countdown_q - 8'd1;

	always_comb begin
		countdown_nxt = countdown_q;
		if (is_learn) begin
			countdown_nxt = (countdown_q != '0) ? countdown_dec : length_q;
		end
		ctl.cmd       = command;
		ctl.slot      = slot;
		ctl.widen     = is_learn && (countdown_q != '0) && (countdown_dec < widen_below_q);
		ctl.done      = is_learn && (countdown_q == '0);
		ctl.remaining = countdown_nxt;
		ctl.mask      = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q       <= DEBOUNCE_LIMIT_RST;
			length_q      <= LEARN_LENGTH_RST;
			widen_below_q <= LEARN_WIDEN_BELOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_LIMIT:    limit_q       <= cfg_data;
				REG_LEARN_LENGTH:      length_q      <= cfg_data;
				REG_LEARN_WIDEN_BELOW: widen_below_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= LEARN_LENGTH_RST;
		end else if (accept) begin
			countdown_q <= countdown_nxt;
		end
	end

	// countdown moves only on an accepted learn beat
	a_cd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && is_learn) |=> $stable(countdown_q))
		else $error("countdown moved without a learn beat");

	// end of run reloads from the length register
	a_cd_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_learn && countdown_q == '0) |=> countdown_q == $past(length_q))
		else $error("countdown did not reload at end of run");

endmodule

/* src/lswd_cell.sv */
// ----------------------------------------------------------------------------
// lswd_cell: one appliance slot of the detector chain
// Holds the slot window, on flag and debounce counters, updates them as a
// beat passes and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module lswd_cell #(
	parameter int IDX          = 0,
	parameter int SAMPLE_WIDTH = lswd_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         valid_in,
	input  lswd_pkg::lswd_ctl_t          ctl_in,
	input  logic [SAMPLE_WIDTH-1:0]      sample_in,
	input  logic [lswd_pkg::CFG_W-1:0]   debounce_limit,
	output logic                         valid_q,
	output lswd_pkg::lswd_ctl_t          ctl_q,
	output logic [SAMPLE_WIDTH-1:0]      sample_q
);
	import lswd_pkg::*;

	localparam logic [63:0] HIGH_FULL = init_high_f(IDX);
	localparam logic [63:0] LOW_FULL  = init_low_f(IDX);
	localparam logic [SAMPLE_WIDTH-1:0] HIGH_RST = HIGH_FULL[SAMPLE_WIDTH-1:0];
	localparam logic [SAMPLE_WIDTH-1:0] LOW_RST  = LOW_FULL[SAMPLE_WIDTH-1:0];
	localparam logic [MASK_W-1:0] MASK_BIT = (IDX < MASK_W) ? MASK_W'(1 << IDX) : '0;
	localparam logic [5:0] SLOT_ID = 6'(IDX + 1);

	logic [SAMPLE_WIDTH-1:0] high_q, low_q, high_nxt, low_nxt;
	logic [CNT_W-1:0]        on_cnt_q, off_cnt_q, on_cnt_nxt, off_cnt_nxt;
	logic                    on_q, on_nxt;
	logic [CNT_W-1:0]        limit_ext;
	logic                    step;
	logic                    hit;
	logic                    in_window;
	logic                    out_window;
	lswd_ctl_t               ctl_nxt;

	assign step       = advance && valid_in;
	assign limit_ext  = CNT_W'(debounce_limit);
	assign hit        = (6'(ctl_in.slot) == SLOT_ID);
	assign in_window  = (sample_in < high_q) && (sample_in > low_q);
	assign out_window = (sample_in > high_q) || (sample_in < low_q);

	always_comb begin
		high_nxt    = high_q;
		low_nxt     = low_q;
		on_cnt_nxt  = on_cnt_q;
		off_cnt_nxt = off_cnt_q;
		on_nxt      = on_q;
		case (ctl_in.cmd)
			CMD_DETECT: begin
				if (!on_q) begin
					if (in_window) begin
						on_cnt_nxt = on_cnt_q + 16'd1;
						if (on_cnt_nxt == limit_ext) begin
							on_nxt = 1'b1;
						end
					end else if (on_cnt_q != '0) begin
						on_cnt_nxt = on_cnt_q - 16'd1;
					end
				end
				if (on_nxt) begin
					if (out_window) begin
						off_cnt_nxt = off_cnt_q + 16'd1;
						if (off_cnt_nxt == limit_ext) begin
							on_nxt = 1'b0;
						end
					end else if (off_cnt_q != '0) begin
						off_cnt_nxt = off_cnt_q - 16'd1;
					end
				end
			end
			CMD_LEARN: begin
				if (hit) begin
					if (high_q == '0 || low_q == '0) begin
						high_nxt = sample_in;
						low_nxt  = sample_in;
					end
					if (ctl_in.widen) begin
						if (high_nxt < sample_in) begin
							high_nxt = sample_in;
						end
						if (low_nxt > sample_in) begin
							low_nxt = sample_in;
						end
					end
				end
			end
			CMD_CLEAR: begin
				high_nxt    = '0;
				low_nxt     = '0;
				on_cnt_nxt  = '0;
				off_cnt_nxt = '0;
				on_nxt      = 1'b0;
			end
			default: ;
		endcase
	end

	// add this slot's on bit to the mask the beat carries
	always_comb begin
		ctl_nxt      = ctl_in;
		ctl_nxt.mask = ctl_in.mask | (on_nxt ? MASK_BIT : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q    <= HIGH_RST;
			low_q     <= LOW_RST;
			on_cnt_q  <= '0;
			off_cnt_q <= '0;
			on_q      <= 1'b0;
		end else if (step) begin
			high_q    <= high_nxt;
			low_q     <= low_nxt;
			on_cnt_q  <= on_cnt_nxt;
			off_cnt_q <= off_cnt_nxt;
			on_q      <= on_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ctl_q    <= ctl_nxt;
			sample_q <= sample_in;
		end
	end

	a_on_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(on_q) && $stable(on_cnt_q) && $stable(off_cnt_q))
		else $error("slot state moved without a passing beat");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(step && ctl_in.cmd == CMD_CLEAR) |=>
			!on_q && on_cnt_q == '0 && off_cnt_q == '0 && high_q == '0 && low_q == '0)
		else $error("clear beat left slot state");

endmodule

/* src/load_signature_window_detector_core.sv */
// ----------------------------------------------------------------------------
// load_signature_window_detector_core: appliance on/off detector
// A chain of slot cells matches each RMS current beat against per-slot
// windows with debounce, learns windows and clears slot state.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+---------------------------------------
//  in_ch     | in  | valid / ready    | command, current_sample, slot
//  out_ch    | out | valid / ready    | on_mask, learn_done, learn_remaining
//  cfg       | in  | cfg_we (no wait) | cfg_index, cfg_data
//
//  One beat enters per cycle while out_ch is not stalled; each beat passes
//  through the slot cells in order, one register per slot, and leaves from
//  the last cell register.
//  arst_n clears all control state, loads the window table and register
//  defaults; there is no clearing pass.
//  A stalled out_ch holds the whole chain; in_ch.ready drops with it.
//
module load_signature_window_detector_core #(
	parameter int NUM_SLOTS    = lswd_pkg::NUM_SLOTS_DEF,
	parameter int SAMPLE_WIDTH = lswd_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	lswd_in_if.sink                          in_ch,
	lswd_out_if.source                       out_ch,
	input  logic                             cfg_we,
	input  logic [lswd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lswd_pkg::CFG_W-1:0]       cfg_data
);
	import lswd_pkg::*;

	// chain taps: index 0 is the head, index k+1 leaves cell k
	logic                    valid_w  [NUM_SLOTS+1];
	lswd_ctl_t               ctl_w    [NUM_SLOTS+1];
	logic [SAMPLE_WIDTH-1:0] sample_w [NUM_SLOTS+1];
	logic [CFG_W-1:0]        debounce_limit;
	logic                    advance;
	logic                    accept;

	// advance the whole chain unless the output beat is stuck
	assign advance     = !valid_w[NUM_SLOTS] || out_ch.ready;
	assign in_ch.ready = advance;
	assign accept      = in_ch.valid && advance;

	// tag the incoming beat with its countdown outcome
	lswd_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.accept         (accept),
		.command        (in_ch.command),
		.slot           (in_ch.slot),
		.ctl            (ctl_w[0]),
		.debounce_limit (debounce_limit)
	);

	assign valid_w[0]  = in_ch.valid;
	assign sample_w[0] = in_ch.current_sample;

	// one cell per slot, each passing the beat on to the next
	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
		lswd_cell #(
			.IDX          (k),
			.SAMPLE_WIDTH (SAMPLE_WIDTH)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.advance        (advance),
			.valid_in       (valid_w[k]),
			.ctl_in         (ctl_w[k]),
			.sample_in      (sample_w[k]),
			.debounce_limit (debounce_limit),
			.valid_q        (valid_w[k+1]),
			.ctl_q          (ctl_w[k+1]),
			.sample_q       (sample_w[k+1])
		);
	end

	// last cell register is the output stage
	assign out_ch.valid           = valid_w[NUM_SLOTS];
	assign out_ch.on_mask         = ctl_w[NUM_SLOTS].mask;
	assign out_ch.learn_done      = ctl_w[NUM_SLOTS].done;
	assign out_ch.learn_remaining = ctl_w[NUM_SLOTS].remaining;

	// a done beat always comes from a learn beat
	a_done_is_learn: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.learn_done |-> ctl_w[NUM_SLOTS].cmd == CMD_LEARN)
		else $error("learn_done on a non-learn beat");

	// with no input beat, the first cell empties on the next advance
	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !in_ch.valid |=> !valid_w[1])
		else $error("beat invented at chain head");

endmodule

/* tb/load_signature_window_detector_core_test.sv */
// ----------------------------------------------------------------------------
// load_signature_window_detector_core_test: self-checking bench of the detector
// Feeds detect, learn, clear and unused-code beats through the valid/ready
// input channel, keeps its own model of the seven slots and the learn countdown
// and checks every status beat in order against that model. Registers change
// only while the block is empty. Both channels idle at random, and once the
// status side holds off long enough for the slot chain to fill up.
// ----------------------------------------------------------------------------
module load_signature_window_detector_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lswd_pkg::*;

	localparam int NSLOT       = NUM_SLOTS_DEF;
	localparam int SW          = SAMPLE_WIDTH_DEF;
	localparam int PERIOD      = 20;
	localparam int LATENCY     = NSLOT;
	localparam int LONG_HOLD   = 400;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 10;
	localparam int PHASE_BEATS = 70;

	// the command field has one code the block does not use
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [SW-1:0]     sample;
		logic [SLOT_W-1:0] slot;
	} meter_beat_t;

	typedef struct packed {
		logic [MASK_W-1:0] on_mask;
		logic              learn_done;
		logic [CFG_W-1:0]  remaining;
	} slot_status_t;

	// where a generated sample lands relative to a learned window
	typedef enum int {NEAR_INSIDE, NEAR_OUTSIDE, NEAR_EDGE} near_t;

	// how the status side fills its next 32-bit ready pattern
	typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	lswd_in_if #(.SAMPLE_WIDTH(SW)) beat_in ();
	lswd_out_if status_out ();

	load_signature_window_detector_core #(
		.NUM_SLOTS(NSLOT),
		.SAMPLE_WIDTH(SW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(beat_in),
		.out_ch(status_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Slot model: windows, debounce counters, on flags, shared countdown and
	// the three registers, all at the block's widths.
	// ------------------------------------------------------------------------
	logic [SW-1:0]    hi_edge [NSLOT];
	logic [SW-1:0]    lo_edge [NSLOT];
	logic [CNT_W-1:0] rise_cnt [NSLOT];
	logic [CNT_W-1:0] fall_cnt [NSLOT];
	logic             lit [NSLOT];
	logic [CFG_W-1:0] learn_left;
	logic [CFG_W-1:0] switch_count;
	logic [CFG_W-1:0] reload_len;
	logic [CFG_W-1:0] widen_mark;

	meter_beat_t  pending_beats [$];
	slot_status_t due_status [$];
	int mismatches = 0;

	// Advance the slot model by one accepted beat and return its status.
	function automatic slot_status_t apply_meter_beat(meter_beat_t b);
		slot_status_t st;
		bit slot_ok;
		int k;
		int j;
		st = '0;
		slot_ok = (b.slot >= 1) && (b.slot <= NSLOT);
		k = slot_ok ? int'(b.slot) - 1 : 0;
		case (b.cmd)
			CMD_DETECT: begin
				for (j = 0; j < NSLOT; j++) begin
					// off slot: count toward on while strictly inside
					if (!lit[j]) begin
						if (b.sample < hi_edge[j] && b.sample > lo_edge[j]) begin
							rise_cnt[j] = rise_cnt[j] + 1'b1;
							if (rise_cnt[j] == CNT_W'(switch_count))
								lit[j] = 1'b1;
						end else if (rise_cnt[j] != '0) begin
							rise_cnt[j] = rise_cnt[j] - 1'b1;
						end
					end
					// on slot, including one that just turned on
					if (lit[j]) begin
						if (b.sample > hi_edge[j] || b.sample < lo_edge[j]) begin
							fall_cnt[j] = fall_cnt[j] + 1'b1;
							if (fall_cnt[j] == CNT_W'(switch_count))
								lit[j] = 1'b0;
						end else if (fall_cnt[j] != '0) begin
							fall_cnt[j] = fall_cnt[j] - 1'b1;
						end
					end
				end
			end
			CMD_LEARN: begin
				// an empty window snaps to the sample first
				if (slot_ok && (hi_edge[k] == '0 || lo_edge[k] == '0)) begin
					hi_edge[k] = b.sample;
					lo_edge[k] = b.sample;
				end
				if (learn_left != '0) begin
					learn_left = learn_left - 1'b1;
					if (slot_ok && learn_left < widen_mark) begin
						if (hi_edge[k] < b.sample)
							hi_edge[k] = b.sample;
						if (lo_edge[k] > b.sample)
							lo_edge[k] = b.sample;
					end
				end else begin
					learn_left = reload_len;
					st.learn_done = 1'b1;
				end
			end
			CMD_CLEAR: begin
				for (j = 0; j < NSLOT; j++) begin
					hi_edge[j] = '0;
					lo_edge[j] = '0;
					rise_cnt[j] = '0;
					fall_cnt[j] = '0;
					lit[j] = 1'b0;
				end
			end
			default: ;
		endcase
		for (j = 0; j < NSLOT; j++)
			st.on_mask[j] = lit[j];
		st.remaining = learn_left;
		return st;
	endfunction

	task automatic report_mismatch(string what, logic [SW-1:0] got, logic [SW-1:0] want);
		$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	logic [SW-1:0] gen_center [1:NSLOT];
	logic [SW-1:0] gen_spread [1:NSLOT];

	function automatic void push_beat(logic [CMD_W-1:0] cmd, logic [SW-1:0] smp,
			logic [SLOT_W-1:0] sl);
		meter_beat_t b;
		b.cmd = cmd;
		b.sample = smp;
		b.slot = sl;
		pending_beats.push_back(b);
	endfunction

	// Pick a sample around the window meant for slot s. Centers stay far from
	// both ends of the range, so none of this wraps.
	function automatic logic [SW-1:0] near_sample(int s, near_t where);
		logic [SW-1:0] c;
		logic [SW-1:0] d;
		c = gen_center[s];
		d = gen_spread[s];
		case (where)
			NEAR_INSIDE:
				return c - d + 1 + $urandom_range(0, 2 * d - 2);
			NEAR_OUTSIDE:
				return $urandom_range(0, 1) ? c + d + 1 + $urandom_range(0, d)
				                            : c - d - 1 - $urandom_range(0, d);
			default:
				return $urandom_range(0, 1) ? c + d : c - d;
		endcase
	endfunction

	// Low, high, high, low: whatever the countdown phase, each edge lands on
	// a beat that may widen the window.
	function automatic void push_learn_window(int s);
		logic [SW-1:0] lo;
		logic [SW-1:0] hi;
		lo = gen_center[s] - gen_spread[s];
		hi = gen_center[s] + gen_spread[s];
		push_beat(CMD_LEARN, lo, SLOT_W'(s));
		push_beat(CMD_LEARN, hi, SLOT_W'(s));
		push_beat(CMD_LEARN, hi, SLOT_W'(s));
		push_beat(CMD_LEARN, lo, SLOT_W'(s));
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_DEBOUNCE_LIMIT:    switch_count = val;
			REG_LEARN_LENGTH:      reload_len = val;
			REG_LEARN_WIDEN_BELOW: widen_mark = val;
			default: ;
		endcase
	endtask

	// Sample at the falling edge so the driver's last updates are visible,
	// then let the chain drain.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_beats.size() != 0 || beat_in.valid || due_status.size() != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Driver: pop pending beats in bursts of random length with random gaps.
	// Hold a beat until it is taken, then advance.
	// ------------------------------------------------------------------------
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		meter_beat_t nxt;
		if (arst_n && (!beat_in.valid || beat_in.ready)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				beat_in.valid <= 1'b0;
			end else if (pending_beats.size() != 0) begin
				nxt = pending_beats.pop_front();
				beat_in.valid <= 1'b1;
				beat_in.command <= nxt.cmd;
				beat_in.current_sample <= nxt.sample;
				beat_in.slot <= nxt.slot;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					// a third of the bursts run straight into the next one
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				beat_in.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Status side: walk a 32-bit ready pattern, reload it with a fresh mode
	// once it has been walked through, and serve long hold-offs when asked.
	// ------------------------------------------------------------------------
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int pattern_bit = 0;
	logic [31:0] ready_pattern = '1;

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				status_out.ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served <= holds_served + 1;
				hold_left <= LONG_HOLD;
				status_out.ready <= 1'b0;
			end else begin
				status_out.ready <= ready_pattern[pattern_bit];
				if (pattern_bit == 31) begin
					pattern_bit <= 0;
					case (rx_mode_t'($urandom_range(0, 3)))
						RX_ALWAYS: ready_pattern <= '1;
						RX_COIN:   ready_pattern <= $urandom;
						RX_MOSTLY: ready_pattern <= $urandom | $urandom;
						default:   ready_pattern <= $urandom & $urandom;
					endcase
				end else begin
					pattern_bit <= pattern_bit + 1;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predict on every accepted input beat, check every accepted
	// status beat against the oldest prediction, field by field.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		meter_beat_t seen;
		slot_status_t want;
		if (arst_n) begin
			if (beat_in.valid && beat_in.ready) begin
				seen.cmd = beat_in.command;
				seen.sample = beat_in.current_sample;
				seen.slot = beat_in.slot;
				due_status.push_back(apply_meter_beat(seen));
			end
			if (status_out.valid && status_out.ready) begin
				if (due_status.size() == 0) begin
					report_mismatch("status beat with none due, on_mask",
						SW'(status_out.on_mask), '0);
				end else begin
					want = due_status.pop_front();
					if (status_out.on_mask !== want.on_mask)
						report_mismatch("on_mask", SW'(status_out.on_mask), SW'(want.on_mask));
					if (status_out.learn_done !== want.learn_done)
						report_mismatch("learn_done", SW'(status_out.learn_done),
							SW'(want.learn_done));
					if (status_out.learn_remaining !== want.remaining)
						report_mismatch("learn_remaining", SW'(status_out.learn_remaining),
							SW'(want.remaining));
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	int cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: reset, directed beats, a long-debounce phase, random phases.
	// ------------------------------------------------------------------------
	initial begin
		int k;
		int s;
		int phase;
		int pick;
		int r;
		near_t where;
		logic [CFG_W-1:0] lim_v;
		logic [CFG_W-1:0] len_v;
		logic [CFG_W-1:0] wid_v;

		beat_in.valid = 1'b0;
		beat_in.command = CMD_DETECT;
		beat_in.current_sample = '0;
		beat_in.slot = '0;
		status_out.ready = 1'b0;

		// load the model with the reset state
		switch_count = DEBOUNCE_LIMIT_RST;
		reload_len = LEARN_LENGTH_RST;
		widen_mark = LEARN_WIDEN_BELOW_RST;
		learn_left = LEARN_LENGTH_RST;
		for (k = 0; k < NSLOT; k++) begin
			hi_edge[k] = (k < INIT_ENTRIES) ? INIT_HIGH[k][SW-1:0] : '0;
			lo_edge[k] = (k < INIT_ENTRIES) ? INIT_LOW[k][SW-1:0] : '0;
			rise_cnt[k] = '0;
			fall_cnt[k] = '0;
			lit[k] = 1'b0;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset registers. Slot 1 turns on after three beats
		// strictly inside its table window, then off after three far below.
		repeat (3) push_beat(CMD_DETECT, INIT_LOW[0][SW-1:0] + 1, 3'd0);
		repeat (3) push_beat(CMD_DETECT, '0, 3'd0);
		// window edges themselves count neither way
		push_beat(CMD_DETECT, INIT_HIGH[0][SW-1:0], 3'd7);
		push_beat(CMD_DETECT, INIT_LOW[6][SW-1:0], 3'd7);
		push_beat(CMD_DETECT, '1, 3'd5);
		// unused code: no state change
		push_beat(CMD_UNUSED, 32'hA5A5_5A5A, 3'd7);
		// learn with slot zero only runs the countdown
		push_beat(CMD_LEARN, 32'h1234_5678, 3'd0);
		push_beat(CMD_LEARN, INIT_HIGH[6][SW-1:0] + 10, 3'd7);
		push_beat(CMD_CLEAR, '1, 3'd7);
		// an empty window snaps to the learned sample
		push_beat(CMD_LEARN, 32'h00A0_0000, 3'd3);
		push_beat(CMD_DETECT, 32'h00A0_0000, 3'd0);
		// a zero sample leaves the window empty, so the next one snaps again
		push_beat(CMD_LEARN, '0, 3'd5);
		push_beat(CMD_LEARN, 32'h0000_0100, 3'd5);
		push_beat(CMD_DETECT, 32'hAAAA_AAAA, 3'd2);
		push_beat(CMD_DETECT, 32'h5555_5555, 3'd4);
		push_beat(CMD_DETECT, 32'h0000_0100, 3'd1);

		// Top debounce limit: learn one wide window after a clear, then sit
		// inside it long enough for the on counter to reach 255.
		wait_idle();
		write_reg(REG_DEBOUNCE_LIMIT, 8'd255);
		write_reg(REG_LEARN_WIDEN_BELOW, 8'd255);
		cfg_we <= 1'b0;
		gen_center[4] = 32'h4000_0000;
		gen_spread[4] = 32'd5000;
		push_beat(CMD_CLEAR, '0, 3'd0);
		push_learn_window(4);
		repeat (256) push_beat(CMD_DETECT, gen_center[4], 3'd0);
		repeat (4) push_beat(CMD_DETECT, near_sample(4, NEAR_OUTSIDE), 3'd0);

		// Random phases: new registers each time, then learned windows and
		// debounce runs against them, with some noise and clears mixed in.
		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			if (phase == 0)
				lim_v = 8'd1;
			else if (phase == 1)
				lim_v = 8'd0;   // switches only on a 16-bit wrap
			else if (phase == 2)
				lim_v = 8'd2;
			else if ($urandom_range(0, 5) == 0)
				lim_v = 8'($urandom_range(6, 255));
			else
				lim_v = 8'($urandom_range(1, 5));
			if (phase == 0)
				len_v = 8'd1;
			else if (phase == 3)
				len_v = 8'd255;
			else
				len_v = 8'($urandom_range(1, 20));
			if (phase == 0)
				wid_v = 8'd255;
			else if (phase == 4)
				wid_v = 8'd0;
			else
				wid_v = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(0, 255));
			write_reg(REG_DEBOUNCE_LIMIT, lim_v);
			write_reg(REG_LEARN_LENGTH, len_v);
			write_reg(REG_LEARN_WIDEN_BELOW, wid_v);
			cfg_we <= 1'b0;

			// hold the status side off while this phase streams in
			if (phase == 5)
				hold_requests++;

			for (s = 1; s <= NSLOT; s++) begin
				gen_center[s] = $urandom_range(32'h0010_0000, 32'hFFEF_FFFF);
				gen_spread[s] = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 32'h1_0000);
			end
			if ($urandom_range(0, 1))
				push_beat(CMD_CLEAR, $urandom, SLOT_W'($urandom_range(0, 7)));
			for (s = 1; s <= NSLOT; s++)
				if ($urandom_range(0, 2) != 0)
					push_learn_window(s);

			while (pending_beats.size() < PHASE_BEATS) begin
				pick = $urandom_range(0, 99);
				s = $urandom_range(1, NSLOT);
				if (pick < 70) begin
					r = $urandom_range(0, 99);
					where = (r < 50) ? NEAR_INSIDE : (r < 85) ? NEAR_OUTSIDE : NEAR_EDGE;
					repeat ($urandom_range(1, 8))
						push_beat(CMD_DETECT, near_sample(s, where), SLOT_W'($urandom));
				end else if (pick < 82) begin
					push_beat(CMD_LEARN, near_sample(s, NEAR_INSIDE), SLOT_W'(s));
				end else if (pick < 96) begin
					push_beat(CMD_W'($urandom_range(0, 3)), $urandom,
						SLOT_W'($urandom_range(0, 7)));
				end else begin
					push_beat(CMD_CLEAR, $urandom, SLOT_W'($urandom));
				end
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* sim.f */
src/lswd_pkg.sv
src/lswd_if.sv
src/lswd_ctrl.sv
src/lswd_cell.sv
src/load_signature_window_detector_core.sv
tb/load_signature_window_detector_core_test.sv
